/* design/rlc_pkg.sv */
// Package for the rumble level controller: request and response word types,
// request type codes and register indexes. No dependencies.
package rlc_pkg;

   localparam int FIELD_LEVEL_BITS = 16;
   localparam int FIELD_TIME_BITS  = 16;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int CSR_DATA_BITS    = 16;

   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_BASE  = 3'd1;
   localparam logic [2:0] REQ_PULSE = 3'd2;
   localparam logic [2:0] REQ_STOP  = 3'd3;
   localparam logic [2:0] REQ_MENU  = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REFRESH_INTERVAL = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESPECT_GAME     = 1'd1;

   localparam logic [15:0] REFRESH_INTERVAL_RESET = 16'd100;

   typedef struct packed {
      logic [2:0]                  req_type;
      logic [FIELD_LEVEL_BITS-1:0] level_large;
      logic [FIELD_LEVEL_BITS-1:0] level_small;
      logic [FIELD_TIME_BITS-1:0]  time_amount;
      logic                        game_allows;
      logic                        paused;
      logic                        menu_opening;
      logic                        pad_present;
   } rlc_req_type;

   typedef struct packed {
      logic [FIELD_LEVEL_BITS-1:0] motor_large;
      logic [FIELD_LEVEL_BITS-1:0] motor_small;
   } rlc_rsp_type;

   typedef struct packed {
      logic        valid;
      rlc_rsp_type data;
   } rlc_result_type;

endpackage

/* design/rumble_level_controller_unit.sv */
// Top level of the rumble level controller: request port, register port and
// level word output. Depends on rlc_pkg, rlc_core and rlc_out_buf.
//
// The unit takes one request word per clock cycle while req_stall is low. Each
// word is handled in the cycle it is accepted; a level word it causes reaches
// rsp via a two-entry output queue. Requests are stalled only while both queue
// entries hold words that the receiver has not taken, so a single stalled
// result never holds up the request side. Registers are written through the
// csr port at any edge with csr_write_enable high and take effect for the next
// request; they should be written only while no level word is pending.
module rumble_level_controller_unit
   import rlc_pkg::*;
#(
   parameter int LEVEL_BITS = 16,
   parameter int TIME_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rlc_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rlc_rsp_type               rsp_data
);

   logic           accept;
   logic           queue_full;
   rlc_result_type result;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   rlc_core #(
      .LEVEL_BITS(LEVEL_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .accept          (accept),
      .req             (req_data),
      .result          (result)
   );

   rlc_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (result),
      .full     (queue_full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

/* design/rlc_core.sv */
// Controller state, configuration registers and the per-word level logic.
// Depends on rlc_pkg.
module rlc_core
   import rlc_pkg::*;
#(
   parameter int LEVEL_BITS = 16,
   parameter int TIME_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      accept,
   input  rlc_req_type               req,
   output rlc_result_type            result
);

   localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);

   logic [15:0]           refresh_interval_ff;
   logic                  respect_game_ff;
   logic [LEVEL_BITS-1:0] base_large_ff, base_large_in;
   logic [LEVEL_BITS-1:0] base_small_ff, base_small_in;
   logic [LEVEL_BITS-1:0] pulse_large_ff, pulse_large_in;
   logic [LEVEL_BITS-1:0] pulse_small_ff, pulse_small_in;
   logic [TIME_BITS-1:0]  pulse_remaining_ff, pulse_remaining_in;
   logic [TIME_BITS-1:0]  refresh_elapsed_ff, refresh_elapsed_in;
   logic [LEVEL_BITS-1:0] applied_large_ff, applied_large_in;
   logic [LEVEL_BITS-1:0] applied_small_ff, applied_small_in;
   logic                  allowed_ff, allowed_in;

   logic [LEVEL_BITS-1:0] lg_in, sm_in;
   logic [31:0]           amount_wide;
   logic [TIME_BITS-1:0]  amount;
   logic                  permission;
   logic [TIME_BITS-1:0]  rem_next;
   logic [TIME_BITS:0]    elapsed_sum;
   logic [TIME_BITS-1:0]  elapsed_sat;
   logic [LEVEL_BITS-1:0] tick_large, tick_small;
   logic                  changed;
   logic                  motors_running;
   logic                  drive;
   logic [LEVEL_BITS-1:0] drive_large, drive_small;

   always_comb begin
      lg_in = req.level_large[LEVEL_BITS-1:0];
      sm_in = req.level_small[LEVEL_BITS-1:0];
      amount_wide = 32'(req.time_amount);
      amount = (amount_wide > TIME_MAX) ? '1 : amount_wide[TIME_BITS-1:0];
      permission = respect_game_ff ? req.game_allows : 1'b1;
      motors_running = (applied_large_ff != '0) || (applied_small_ff != '0);

      // Tick path: countdown, merged level, and the saturating refresh timer.
      rem_next = (pulse_remaining_ff > amount) ? pulse_remaining_ff - amount : '0;
      tick_large = base_large_ff;
      tick_small = base_small_ff;
      if (rem_next != '0) begin
         if (pulse_large_ff > tick_large) tick_large = pulse_large_ff;
         if (pulse_small_ff > tick_small) tick_small = pulse_small_ff;
      end
      if (!allowed_ff || req.paused) begin
         tick_large = '0;
         tick_small = '0;
      end
      elapsed_sum = {1'b0, refresh_elapsed_ff} + {1'b0, amount};
      elapsed_sat = elapsed_sum[TIME_BITS] ? '1 : elapsed_sum[TIME_BITS-1:0];
      changed = (tick_large != applied_large_ff) || (tick_small != applied_small_ff);

      base_large_in      = base_large_ff;
      base_small_in      = base_small_ff;
      pulse_large_in     = pulse_large_ff;
      pulse_small_in     = pulse_small_ff;
      pulse_remaining_in = pulse_remaining_ff;
      refresh_elapsed_in = refresh_elapsed_ff;
      allowed_in         = allowed_ff;
      drive       = 1'b0;
      drive_large = '0;
      drive_small = '0;

      unique case (req.req_type)
         REQ_TICK: begin
            pulse_remaining_in = rem_next;
            refresh_elapsed_in = elapsed_sat;
            if (changed || ((32'(elapsed_sat) >= 32'(refresh_interval_ff)) &&
                            ((tick_large != '0) || (tick_small != '0)))) begin
               refresh_elapsed_in = '0;
               drive       = 1'b1;
               drive_large = tick_large;
               drive_small = tick_small;
            end
         end
         REQ_BASE: begin
            base_large_in = lg_in;
            base_small_in = sm_in;
            allowed_in    = permission;
         end
         REQ_PULSE: begin
            // Zero duration or an all-zero pulse leaves everything alone.
            if ((amount != '0) && ((lg_in != '0) || (sm_in != '0))) begin
               if ((base_large_ff == '0) && (base_small_ff == '0)) allowed_in = permission;
               pulse_large_in     = lg_in;
               pulse_small_in     = sm_in;
               pulse_remaining_in = amount;
            end
         end
         REQ_STOP: begin
            base_large_in      = '0;
            base_small_in      = '0;
            pulse_remaining_in = '0;
            drive              = motors_running;
         end
         REQ_MENU: begin
            drive = req.menu_opening && req.paused && motors_running;
         end
         default: begin
         end
      endcase

      applied_large_in = drive ? drive_large : applied_large_ff;
      applied_small_in = drive ? drive_small : applied_small_ff;

      result.valid            = accept && drive && req.pad_present;
      result.data.motor_large = FIELD_LEVEL_BITS'(drive_large);
      result.data.motor_small = FIELD_LEVEL_BITS'(drive_small);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_interval_ff <= REFRESH_INTERVAL_RESET;
         respect_game_ff     <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REFRESH_INTERVAL: refresh_interval_ff <= csr_write_data;
            CSR_RESPECT_GAME:     respect_game_ff     <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_large_ff      <= '0;
         base_small_ff      <= '0;
         pulse_large_ff     <= '0;
         pulse_small_ff     <= '0;
         pulse_remaining_ff <= '0;
         refresh_elapsed_ff <= '0;
         applied_large_ff   <= '0;
         applied_small_ff   <= '0;
         allowed_ff         <= 1'b0;
      end else if (accept) begin
         base_large_ff      <= base_large_in;
         base_small_ff      <= base_small_in;
         pulse_large_ff     <= pulse_large_in;
         pulse_small_ff     <= pulse_small_in;
         pulse_remaining_ff <= pulse_remaining_in;
         refresh_elapsed_ff <= refresh_elapsed_in;
         applied_large_ff   <= applied_large_in;
         applied_small_ff   <= applied_small_in;
         allowed_ff         <= allowed_in;
      end
   end

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req.req_type == REQ_STOP) |=>
         (pulse_remaining_ff == '0) && (base_large_ff == '0) && (base_small_ff == '0))
      else $error("stop did not clear base and pulse");

   a_no_result_on_set: assert property (@(posedge clock) disable iff (reset)
      accept && ((req.req_type == REQ_BASE) || (req.req_type == REQ_PULSE)) |-> !result.valid)
      else $error("set base or pulse produced a level word");

   a_stop_zero_applied: assert property (@(posedge clock) disable iff (reset)
      accept && (req.req_type == REQ_STOP) |=>
         (applied_large_ff == '0) && (applied_small_ff == '0))
      else $error("stop left a non-zero applied level");

endmodule

/* design/rlc_out_buf.sv */
// Two-entry output queue for level words: an output register and a skid slot.
// Depends on rlc_pkg.
module rlc_out_buf
   import rlc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rlc_result_type push,
   output logic           full,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rlc_rsp_type    rsp_data
);

   logic [1:0]  count_ff, count_in;
   rlc_rsp_type slot0_ff, slot0_in;
   rlc_rsp_type slot1_ff, slot1_in;
   logic        pop;

   always_comb begin
      pop      = (count_ff != 2'd0) && !rsp_stall;
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      // The head always sits in slot0; slot1 only holds a word behind it.
      priority if (pop && push.valid) begin
         if (count_ff == 2'd1) begin
            slot0_in = push.data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push.data;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (push.valid) begin
         if (count_ff == 2'd0) slot0_in = push.data;
         else slot1_in = push.data;
         count_in = count_ff + 2'd1;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("level word pushed into a full output queue");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && (rsp_data == $past(rsp_data)))
      else $error("stalled head word changed");

endmodule
